// ----- design/lfbf_pkg.sv -----
// Shared types and constants for the line framing byte FIFO.
// Used by lfbf_ctrl and line_framing_byte_fifo; depends on nothing.
`timescale 1ns / 1ps

package lfbf_pkg;

	localparam int CNT_W = 11;
	localparam logic [7:0] EOL_CR = 8'h0D;
	localparam logic [7:0] EOL_LF = 8'h0A;

	typedef enum logic [1:0] {
		OP_PUT       = 2'd0,
		OP_GET_MSG   = 2'd1,
		OP_GET_BYTES = 2'd2,
		OP_DELETE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_NO_MSG   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEAD,
		S_LEAD_CHK,
		S_SCAN,
		S_SCAN_CHK,
		S_TRAIL,
		S_TRAIL_CHK,
		S_EMIT_RD,
		S_EMIT_OUT,
		S_SINGLE
	} seq_state_t;

	typedef struct packed {
		status_t           status;
		logic [7:0]        out_byte;
		logic              last;
		logic [CNT_W-1:0]  stored_count;
	} result_t;

	function automatic logic is_eol(input logic [7:0] b);
		return (b == EOL_CR) || (b == EOL_LF);
	endfunction

endpackage

// ----- design/lfbf_ram.sv -----
// Single-port byte store with a registered read port.
// Depends on nothing; instantiated by line_framing_byte_fifo.
`timescale 1ns / 1ps

module lfbf_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata_q
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

endmodule

// ----- design/lfbf_ctrl.sv -----
// Sequencer of the line framing FIFO: head and count registers, one shared
// modular address adder, and the scan/emit state machine. Uses lfbf_pkg.
`timescale 1ns / 1ps

module lfbf_ctrl #(
	parameter int FIFO_DEPTH = 1024,
	parameter int MAX_RUN    = 64,
	parameter int AW         = 10,
	parameter int CW         = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lfbf_pkg::opcode_t  opcode,
	input  logic [7:0]         data_byte,
	input  logic [10:0]        count,
	output logic               mem_we,
	output logic               mem_re,
	output logic [AW-1:0]      mem_addr,
	output logic [7:0]         mem_wdata,
	input  logic [7:0]         mem_rdata,
	output logic               res_valid,
	input  logic               res_ready,
	output lfbf_pkg::result_t  res
);

	import lfbf_pkg::*;

	localparam int RW = $clog2(MAX_RUN + 1);
	localparam int XW = (CW > RW) ? CW : RW;
	localparam int DW = (CW > CNT_W) ? CW : CNT_W;
	localparam logic [CW:0] DEPTH_X = (CW + 1)'(FIFO_DEPTH);

	seq_state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] held_q, held_d;
	logic [CW-1:0] off_q, off_d;
	logic [CW-1:0] total_q, total_d;
	logic [CW-1:0] fin_q, fin_d;
	logic [RW-1:0] lim_q, lim_d;
	logic [RW-1:0] len_q, len_d;
	logic [RW-1:0] cntc_q, cntc_d;
	status_t       pend_q, pend_d;

	logic [CW-1:0] off_sel;
	logic [AW-1:0] addr_sum;
	logic [RW-1:0] cnt_clamp;
	logic [CW-1:0] del_n;
	logic [XW-1:0] lim_calc;
	logic          emit_last;

	// Head plus offset, wrapped once; the offset never exceeds the depth.
	function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW + 1)'(a) + (CW + 1)'(b);
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[AW-1:0];
	endfunction

	assign cnt_clamp = (count > CNT_W'(MAX_RUN)) ? RW'(MAX_RUN) : RW'(count);
	assign del_n     = (DW'(count) > DW'(held_q)) ? held_q : CW'(count);
	assign emit_last = (XW'(off_q) + XW'(1)) == XW'(len_q);

	// Offset feeding the shared address adder.
	always_comb begin
		off_sel = '0;
		case (state_q)
			S_IDLE: begin
				off_sel = (opcode == OP_PUT) ? held_q : del_n;
			end
			S_LEAD_CHK: begin
				off_sel = CW'(1);
			end
			S_SCAN, S_TRAIL, S_EMIT_RD: begin
				off_sel = off_q;
			end
			S_EMIT_OUT: begin
				off_sel = total_q;
			end
			default: begin
				off_sel = '0;
			end
		endcase
	end

	assign addr_sum  = mod_add(head_q, off_sel);
	assign mem_addr  = addr_sum;
	assign mem_wdata = data_byte;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		held_d    = held_q;
		off_d     = off_q;
		total_d   = total_q;
		fin_d     = fin_q;
		lim_d     = lim_q;
		len_d     = len_q;
		cntc_d    = cntc_q;
		pend_d    = pend_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		lim_calc  = '0;
		res.last  = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_ready = res_ready;
				if (in_valid && res_ready) begin
					case (opcode)
						OP_PUT: begin
							res_valid = 1'b1;
							if (held_q == CW'(FIFO_DEPTH)) begin
								res.status       = ST_OVERFLOW;
								res.stored_count = CNT_W'(held_q);
							end else begin
								mem_we           = 1'b1;
								held_d           = held_q + CW'(1);
								res.status       = ST_OK;
								res.stored_count = CNT_W'(held_q + CW'(1));
							end
						end
						OP_GET_MSG: begin
							cntc_d  = cnt_clamp;
							state_d = S_LEAD;
						end
						OP_GET_BYTES: begin
							lim_calc = (XW'(cnt_clamp) > XW'(held_q)) ? XW'(held_q)
								: XW'(cnt_clamp);
							if (lim_calc == '0) begin
								res_valid        = 1'b1;
								res.status       = ST_EMPTY;
								res.stored_count = CNT_W'(held_q);
							end else begin
								len_d   = RW'(lim_calc);
								total_d = CW'(lim_calc);
								fin_d   = held_q - CW'(lim_calc);
								off_d   = '0;
								state_d = S_EMIT_RD;
							end
						end
						default: begin
							head_d           = addr_sum;
							held_d           = held_q - del_n;
							res_valid        = 1'b1;
							res.status       = ST_OK;
							res.stored_count = CNT_W'(held_q - del_n);
						end
					endcase
				end
			end
			S_LEAD: begin
				if (held_q == '0) begin
					pend_d  = ST_EMPTY;
					state_d = S_SINGLE;
				end else begin
					mem_re  = 1'b1;
					state_d = S_LEAD_CHK;
				end
			end
			S_LEAD_CHK: begin
				if (is_eol(mem_rdata)) begin
					head_d  = addr_sum;
					held_d  = held_q - CW'(1);
					state_d = S_LEAD;
				end else begin
					lim_calc = (XW'(cntc_q) > XW'(held_q)) ? XW'(held_q) : XW'(cntc_q);
					lim_d    = RW'(lim_calc);
					off_d    = '0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (XW'(off_q) >= XW'(lim_q)) begin
					pend_d  = ST_NO_MSG;
					state_d = S_SINGLE;
				end else begin
					mem_re  = 1'b1;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				off_d = off_q + CW'(1);
				if (is_eol(mem_rdata)) begin
					len_d   = RW'(off_q);
					state_d = S_TRAIL;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_TRAIL: begin
				if (off_q >= held_q) begin
					total_d = off_q;
					fin_d   = held_q - off_q;
					off_d   = '0;
					state_d = S_EMIT_RD;
				end else begin
					mem_re  = 1'b1;
					state_d = S_TRAIL_CHK;
				end
			end
			S_TRAIL_CHK: begin
				if (is_eol(mem_rdata)) begin
					off_d   = off_q + CW'(1);
					state_d = S_TRAIL;
				end else begin
					total_d = off_q;
					fin_d   = held_q - off_q;
					off_d   = '0;
					state_d = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				mem_re  = 1'b1;
				state_d = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				res_valid        = 1'b1;
				res.status       = ST_OK;
				res.out_byte     = mem_rdata;
				res.last         = emit_last;
				res.stored_count = CNT_W'(fin_q);
				if (res_ready) begin
					if (emit_last) begin
						head_d  = addr_sum;
						held_d  = fin_q;
						state_d = S_IDLE;
					end else begin
						off_d   = off_q + CW'(1);
						state_d = S_EMIT_RD;
					end
				end
			end
			S_SINGLE: begin
				res_valid        = 1'b1;
				res.status       = pend_q;
				res.stored_count = CNT_W'(held_q);
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		off_q   <= off_d;
		total_q <= total_d;
		fin_q   <= fin_d;
		lim_q   <= lim_d;
		len_q   <= len_d;
		cntc_q  <= cntc_d;
		pend_q  <= pend_d;
	end

endmodule

// ----- design/line_framing_byte_fifo.sv -----
// Top level of the CR/LF line framing byte FIFO: byte store, sequencer and
// output register. Depends on lfbf_pkg, lfbf_ram and lfbf_ctrl.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         tuser = opcode; tdata = data_byte, count
// m_axis    out        tuser = status; tdata = out_byte, stored_count; tlast = last
//
// Put, delete, and a get bytes that finds nothing each finish in the idle
// state, so puts run at one beat per cycle while the output register drains.
// Get bytes reads and emits its bytes one by one. Get message drops leading
// CR/LF, scans for the CR/LF that ends the line, skips trailing CR/LF and then
// emits the line byte by byte. Every step goes through the single-port byte
// store with its registered read and the one shared address adder.
// Reset clears the head and count at once; no clearing pass over the store.
// A stalled m_axis holds the result in the output register and the sequencer
// waits; s_axis_tready is low while an item is in progress.
module line_framing_byte_fifo #(
	parameter int FIFO_DEPTH = 1024,
	parameter int MAX_RUN    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [18:8] count, rest zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [18:8] stored_count, rest zero
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast
);

	import lfbf_pkg::*;

	// Address width of the store and width of the held count, which can
	// reach the depth itself.
	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;
	logic          res_valid;
	logic          res_ready;
	result_t       res;
	logic          out_valid_q;
	result_t       out_q;
	logic          out_load;

	lfbf_ram #(
		.DEPTH (FIFO_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.re      (mem_re),
		.addr    (mem_addr),
		.wdata   (mem_wdata),
		.rdata_q (mem_rdata)
	);

	lfbf_ctrl #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.MAX_RUN    (MAX_RUN),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.opcode    (opcode_t'(s_axis_tuser)),
		.data_byte (s_axis_tdata[7:0]),
		.count     (s_axis_tdata[18:8]),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register takes a new result whenever it is empty or its
	// current beat leaves in the same cycle.
	assign res_ready = !out_valid_q || m_axis_tready;
	assign out_load  = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.stored_count, out_q.out_byte};
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tlast  = out_q.last;

endmodule
